// ===== hw/rtl/rzsl_pkg.sv =====
// Shared types, codes and per-side check functions of the radar zone speed limiter.
`default_nettype none

package rzsl_pkg;

    localparam int NUM_SIDES = 4;
    localparam int SPEED_W   = 16;
    localparam int LIMIT_W   = 15;
    localparam int BITS_W    = 5;
    localparam int LINKED_W  = 12;
    localparam int CFG_ADDR_W = 3;

    typedef logic [2:0] t_sev;
    typedef logic [1:0] t_act;
    typedef logic [1:0] t_side;

    localparam t_sev SEV_NORMAL = 3'd0;
    localparam t_sev SEV_WARN   = 3'd1;
    localparam t_sev SEV_CAUT   = 3'd2;
    localparam t_sev SEV_EMERG  = 3'd3;
    localparam t_sev SEV_ERROR  = 3'd4;

    localparam t_act ACT_NONE = 2'd0;
    localparam t_act ACT_WARN = 2'd1;
    localparam t_act ACT_CAUT = 2'd2;
    localparam t_act ACT_STOP = 2'd3;

    localparam t_side SIDE_FRONT = 2'd0;
    localparam t_side SIDE_BACK  = 2'd1;
    localparam t_side SIDE_LEFT  = 2'd2;
    localparam t_side SIDE_RIGHT = 2'd3;

    localparam logic [1:0] SRC_OWN    = 2'd0;
    localparam logic [1:0] SRC_LINKED = 2'd1;
    localparam logic [1:0] SRC_MAX    = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] CFG_STATE_SOURCE = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_Y_WARN       = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_Y_CAUT       = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_X_WARN       = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_X_CAUT       = 3'd4;

    // Radar bit positions
    localparam int RB_EN    = 0;
    localparam int RB_ERR   = 1;
    localparam int RB_INNER = 2;
    localparam int RB_MID   = 3;
    localparam int RB_OUTER = 4;

    typedef struct packed {
        logic [1:0]         source;
        logic [LIMIT_W-1:0] y_warn;
        logic [LIMIT_W-1:0] y_caut;
        logic [LIMIT_W-1:0] x_warn;
        logic [LIMIT_W-1:0] x_caut;
    } t_cfg;

    typedef struct packed {
        logic signed [SPEED_W-1:0] x;
        logic signed [SPEED_W-1:0] y;
        logic signed [SPEED_W-1:0] z;
        logic [NUM_SIDES-1:0]      en;
        t_sev [NUM_SIDES-1:0]      sev;
        t_act [NUM_SIDES-1:0]      act;
        logic                      xnz;
        logic                      ynz;
    } t_item;

    function automatic t_sev own_sev(logic [BITS_W-1:0] b);
        t_sev s;
        if (b[RB_ERR] || b[RB_INNER]) begin
            s = SEV_EMERG;
        end else if (b[RB_MID]) begin
            s = SEV_CAUT;
        end else if (b[RB_OUTER]) begin
            s = SEV_WARN;
        end else begin
            s = SEV_NORMAL;
        end
        return s;
    endfunction

    function automatic logic [2:0] layer_bits(t_sev s);
        logic [2:0] f;
        case (s)
            SEV_EMERG, SEV_ERROR: f = 3'b111;
            SEV_CAUT:             f = 3'b110;
            SEV_WARN:             f = 3'b100;
            default:              f = 3'b000;
        endcase
        return f;
    endfunction

    // One side check on the speeds left by earlier sides.
    function automatic t_item side_step(t_item it, t_side side,
                                        logic [LIMIT_W-1:0] lw, logic [LIMIT_W-1:0] lc);
        t_item                   r;
        logic                    gate;
        logic signed [SPEED_W:0] x17;
        logic signed [SPEED_W:0] y17;
        logic signed [SPEED_W:0] z17;
        logic signed [SPEED_W:0] lim17;
        logic signed [SPEED_W:0] mag;
        t_sev                    s;
        r     = it;
        x17   = (SPEED_W+1)'(it.x);
        y17   = (SPEED_W+1)'(it.y);
        z17   = (SPEED_W+1)'(it.z);
        s     = it.sev[side];
        lim17 = signed'({2'b00, ((s == SEV_WARN) ? lw : lc)});
        mag   = z17[SPEED_W] ? -z17 : z17;
        case (side)
            SIDE_FRONT: gate = (y17 > 0) || (z17 != 0);
            SIDE_BACK:  gate = (y17 < 0) || (z17 != 0);
            SIDE_LEFT:  gate = (x17 < 0) || (z17 != 0);
            default:    gate = (x17 > 0) || (z17 != 0);
        endcase
        if (it.en[side] && gate) begin
            if (s == SEV_EMERG) begin
                r.x = '0;
                r.y = '0;
                r.z = '0;
                r.act[side] = ACT_STOP;
            end else if (s == SEV_WARN || s == SEV_CAUT) begin
                case (side)
                    SIDE_FRONT: if (y17 > lim17) r.y = SPEED_W'(lim17);
                    SIDE_BACK:  if (y17 < -lim17) r.y = SPEED_W'(-lim17);
                    SIDE_LEFT:  if (x17 < -lim17) r.x = SPEED_W'(-lim17);
                    default:    if (x17 > lim17) r.x = SPEED_W'(lim17);
                endcase
                if (mag > lim17) begin
                    r.z = z17[SPEED_W] ? SPEED_W'(-lim17) : SPEED_W'(lim17);
                end
                r.act[side] = (s == SEV_WARN) ? ACT_WARN : ACT_CAUT;
            end
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rzsl_intf.sv =====
// Stream and configuration channel interfaces of the radar zone speed limiter.
`default_nettype none

interface rzsl_in_if;
    import rzsl_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] x_speed;
    logic signed [SPEED_W-1:0] y_speed;
    logic signed [SPEED_W-1:0] z_speed;
    logic [BITS_W-1:0]         front_bits;
    logic [BITS_W-1:0]         back_bits;
    logic [BITS_W-1:0]         left_bits;
    logic [BITS_W-1:0]         right_bits;
    logic [LINKED_W-1:0]       linked_states;

    modport source (output valid, x_speed, y_speed, z_speed, front_bits, back_bits,
                    left_bits, right_bits, linked_states, input ready);
    modport sink   (input valid, x_speed, y_speed, z_speed, front_bits, back_bits,
                    left_bits, right_bits, linked_states, output ready);
    modport mon    (input valid, ready, x_speed, y_speed, z_speed, front_bits, back_bits,
                    left_bits, right_bits, linked_states);
endinterface

interface rzsl_out_if;
    import rzsl_pkg::*;
    logic                      valid;
    logic                      ready;
    logic signed [SPEED_W-1:0] x_limited;
    logic signed [SPEED_W-1:0] y_limited;
    logic signed [SPEED_W-1:0] z_limited;
    logic [1:0]                front_action;
    logic [1:0]                back_action;
    logic [1:0]                left_action;
    logic [1:0]                right_action;
    logic [LINKED_W-1:0]       layer_flags;

    modport source (output valid, x_limited, y_limited, z_limited, front_action,
                    back_action, left_action, right_action, layer_flags, input ready);
    modport sink   (input valid, x_limited, y_limited, z_limited, front_action,
                    back_action, left_action, right_action, layer_flags, output ready);
    modport mon    (input valid, ready, x_limited, y_limited, z_limited, front_action,
                    back_action, left_action, right_action, layer_flags);
endinterface

interface rzsl_cfg_if;
    import rzsl_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] addr;
    logic [LIMIT_W-1:0]    data;

    modport source (output valid, addr, data, input ready);
    modport sink   (input valid, addr, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rzsl_decode.sv =====
// First pipeline stage: radar severity decode and state source selection.
`default_nettype none

module rzsl_decode
    import rzsl_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rzsl_in_if.sink     i_cmd,
    input  wire logic [1:0] i_source,
    output logic        o_valid,
    input  wire logic   i_ready,
    output t_item       o_item
);

    logic             r_valid;
    t_item            r_item;
    t_item            n_item;
    logic             load;
    logic [BITS_W-1:0] bits [NUM_SIDES];
    t_sev             own  [NUM_SIDES];
    t_sev             lk   [NUM_SIDES];

    assign load        = !r_valid || i_ready;
    assign i_cmd.ready = load;

    assign bits[SIDE_FRONT] = i_cmd.front_bits;
    assign bits[SIDE_BACK]  = i_cmd.back_bits;
    assign bits[SIDE_LEFT]  = i_cmd.left_bits;
    assign bits[SIDE_RIGHT] = i_cmd.right_bits;

    always_comb begin
        n_item     = '0;
        n_item.x   = i_cmd.x_speed;
        n_item.y   = i_cmd.y_speed;
        n_item.z   = i_cmd.z_speed;
        n_item.xnz = |i_cmd.x_speed;
        n_item.ynz = |i_cmd.y_speed;
        for (int i = 0; i < NUM_SIDES; i++) begin
            n_item.en[i] = bits[i][RB_EN];
            own[i] = own_sev(bits[i]);
            lk[i]  = i_cmd.linked_states[3*i +: 3];
            // saturate undefined linked codes to error
            if (lk[i] > SEV_ERROR) lk[i] = SEV_ERROR;
            case (i_source)
                SRC_LINKED: n_item.sev[i] = lk[i];
                SRC_MAX:    n_item.sev[i] = (own[i] > lk[i]) ? own[i] : lk[i];
                default:    n_item.sev[i] = own[i];
            endcase
            n_item.act[i] = ACT_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_cmd.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_cmd.valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== hw/rtl/rzsl_clamp.sv =====
// Clamp stage: checks one pair of sides in order, front/back or left/right.
`default_nettype none

module rzsl_clamp
    import rzsl_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_lateral,
    input  wire logic [LIMIT_W-1:0] i_lim_warn,
    input  wire logic [LIMIT_W-1:0] i_lim_caut,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire t_item              i_item,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output t_item                   o_item
);

    logic  r_valid;
    t_item r_item;
    t_item mid;
    t_item n_item;
    logic  load;

    assign load    = !r_valid || i_ready;
    assign o_ready = load;

    // Second side sees the speeds left by the first.
    always_comb begin
        mid    = side_step(i_item, {i_lateral, 1'b0}, i_lim_warn, i_lim_caut);
        n_item = side_step(mid, {i_lateral, 1'b1}, i_lim_warn, i_lim_caut);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== hw/rtl/rzsl_stop.sv =====
// Last stage: side emergency stop, layer flags and the result register.
`default_nettype none

module rzsl_stop
    import rzsl_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_valid,
    output logic       o_ready,
    input  wire t_item i_item,
    rzsl_out_if.source o_res
);

    logic                 r_valid;
    t_item                r_item;
    logic [LINKED_W-1:0]  r_flags;
    t_item                n_item;
    logic [LINKED_W-1:0]  n_flags;
    logic                 load;
    logic                 cmd;

    assign load    = !r_valid || o_res.ready;
    assign o_ready = load;

    always_comb begin
        n_item  = i_item;
        n_flags = '0;
        cmd     = 1'b0;
        for (int i = 0; i < NUM_SIDES; i++) begin
            // front/back stop on lateral command, left/right on longitudinal
            cmd = (i < 2) ? i_item.xnz : i_item.ynz;
            if (cmd && i_item.en[i] && i_item.sev[i] == SEV_EMERG) begin
                n_item.x = '0;
                n_item.y = '0;
                n_item.z = '0;
                n_item.act[i] = ACT_STOP;
            end
            n_flags[3*i +: 3] = layer_bits(i_item.sev[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_valid) begin
            r_item  <= n_item;
            r_flags <= n_flags;
        end
    end

    assign o_res.valid        = r_valid;
    assign o_res.x_limited    = r_item.x;
    assign o_res.y_limited    = r_item.y;
    assign o_res.z_limited    = r_item.z;
    assign o_res.front_action = r_item.act[SIDE_FRONT];
    assign o_res.back_action  = r_item.act[SIDE_BACK];
    assign o_res.left_action  = r_item.act[SIDE_LEFT];
    assign o_res.right_action = r_item.act[SIDE_RIGHT];
    assign o_res.layer_flags  = r_flags;

endmodule

`default_nettype wire

// ===== hw/rtl/radar_zone_speed_limiter_core.sv =====
// Radar zone speed limiter top level: configuration registers and four-stage pipeline.
//
// Takes one speed command per clock while the result is not stalled and returns its
// limited speeds, per-side actions and layer flags through four registered stages (decode,
// front/back clamp, left/right clamp, emergency stop with result register). Throughput is
// one item per cycle; a stalled result holds the pipeline in place and each stage refills
// as soon as the one after it moves. Configuration writes are accepted in every cycle and
// take effect once registered, also on items in flight; write them only while no item is in flight.
`default_nettype none

module radar_zone_speed_limiter_core
    import rzsl_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rzsl_cfg_if.sink   i_cfg,
    rzsl_in_if.sink    i_cmd,
    rzsl_out_if.source o_res
);

    t_cfg  r_cfg;
    logic  s1_valid, s1_ready;
    logic  s2_valid, s2_ready;
    logic  s3_valid, s3_ready;
    t_item s1_item, s2_item, s3_item;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg.valid) begin
            case (i_cfg.addr)
                CFG_STATE_SOURCE: r_cfg.source <= i_cfg.data[1:0];
                CFG_Y_WARN:       r_cfg.y_warn <= i_cfg.data;
                CFG_Y_CAUT:       r_cfg.y_caut <= i_cfg.data;
                CFG_X_WARN:       r_cfg.x_warn <= i_cfg.data;
                CFG_X_CAUT:       r_cfg.x_caut <= i_cfg.data;
                default: ;
            endcase
        end
    end

    rzsl_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (i_cmd),
        .i_source (r_cfg.source),
        .o_valid  (s1_valid),
        .i_ready  (s1_ready),
        .o_item   (s1_item)
    );

    rzsl_clamp u_clamp_fb (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_lateral  (1'b0),
        .i_lim_warn (r_cfg.y_warn),
        .i_lim_caut (r_cfg.y_caut),
        .i_valid    (s1_valid),
        .o_ready    (s1_ready),
        .i_item     (s1_item),
        .o_valid    (s2_valid),
        .i_ready    (s2_ready),
        .o_item     (s2_item)
    );

    rzsl_clamp u_clamp_lr (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_lateral  (1'b1),
        .i_lim_warn (r_cfg.x_warn),
        .i_lim_caut (r_cfg.x_caut),
        .i_valid    (s2_valid),
        .o_ready    (s2_ready),
        .i_item     (s2_item),
        .o_valid    (s3_valid),
        .i_ready    (s3_ready),
        .o_item     (s3_item)
    );

    rzsl_stop u_stop (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s3_valid),
        .o_ready (s3_ready),
        .i_item  (s3_item),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/rzsl_checker.sv =====
// Port-level checks of the radar zone speed limiter, bound to the top level.
`default_nettype none

module rzsl_checker
    import rzsl_pkg::*;
(
    input wire logic                      i_clk,
    input wire logic                      i_rst_n,
    input wire logic                      i_res_valid,
    input wire logic                      i_res_ready,
    input wire logic signed [SPEED_W-1:0] i_x_limited,
    input wire logic signed [SPEED_W-1:0] i_y_limited,
    input wire logic signed [SPEED_W-1:0] i_z_limited,
    input wire t_act                      i_front_action,
    input wire t_act                      i_back_action,
    input wire t_act                      i_left_action,
    input wire t_act                      i_right_action,
    input wire logic [LINKED_W-1:0]       i_layer_flags
);

    // hold a stalled result
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_x_limited)
            && $stable(i_layer_flags))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_res_valid)
        else $error("result valid right after reset");

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_front_action == ACT_STOP || i_back_action == ACT_STOP
            || i_left_action == ACT_STOP || i_right_action == ACT_STOP)
        |-> i_x_limited == 0 && i_y_limited == 0 && i_z_limited == 0)
        else $error("stop with nonzero speed");

    a_front_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_front_action == ACT_WARN || i_front_action == ACT_CAUT)
        |-> i_layer_flags[2:0] == ((i_front_action == ACT_WARN) ? 3'b100 : 3'b110))
        else $error("front action and layer flags disagree");

endmodule

bind radar_zone_speed_limiter_core rzsl_checker u_rzsl_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_res_valid    (o_res.valid),
    .i_res_ready    (o_res.ready),
    .i_x_limited    (o_res.x_limited),
    .i_y_limited    (o_res.y_limited),
    .i_z_limited    (o_res.z_limited),
    .i_front_action (o_res.front_action),
    .i_back_action  (o_res.back_action),
    .i_left_action  (o_res.left_action),
    .i_right_action (o_res.right_action),
    .i_layer_flags  (o_res.layer_flags)
);

`default_nettype wire
